// File: rtl/mipx_pkg.sv
// Shared types, constants and format tables for the mip extent pipeline.
`timescale 1ns / 1ps
package mipx_pkg;

	localparam int unsigned DIM_W       = 16;
	localparam int unsigned EXT_W       = 17;
	localparam int unsigned FMT_W       = 7;
	localparam int unsigned CNT_W       = 5;
	localparam int unsigned LVL_W       = 4;
	localparam int unsigned BLK_W       = 4;
	localparam int unsigned MINB_W      = 2;
	localparam int unsigned RECIP_SHIFT = 20;
	localparam int unsigned RECIP_W     = 21;
	localparam int unsigned PROD_W      = EXT_W + RECIP_W;
	localparam int unsigned WALK_STEPS  = (1 << LVL_W) - 1;
	localparam int unsigned FRONT_STAGES = 3;
	localparam int unsigned LATENCY     = FRONT_STAGES + WALK_STEPS + 1;

	localparam logic [FMT_W-1:0] FIRST_PLAIN_FMT = 7'd26;
	localparam logic [CNT_W-1:0] MAX_LEVELS      = 5'd16;

	typedef struct packed {
		logic [BLK_W-1:0]  bw;
		logic [BLK_W-1:0]  bh;
		logic [MINB_W-1:0] mb;
	} blk_t;

	typedef struct packed {
		logic              comp;
		logic [CNT_W-1:0]  steps;
		logic [BLK_W-1:0]  bw;
		logic [BLK_W-1:0]  bh;
		logic [MINB_W-1:0] mb;
		logic [EXT_W-1:0]  qw;
		logic [EXT_W-1:0]  qh;
		logic [DIM_W-1:0]  d;
	} item_t;

	function automatic blk_t blk_of(input logic [FMT_W-1:0] fmt);
		blk_t b;
		case (fmt) inside
			[7'd0:7'd10], [7'd17:7'd20]: b = '{bw: 4'd4,  bh: 4'd4, mb: 2'd1};
			7'd11, 7'd13, 7'd15:         b = '{bw: 4'd8,  bh: 4'd4, mb: 2'd2};
			7'd12, 7'd14, 7'd16:         b = '{bw: 4'd4,  bh: 4'd4, mb: 2'd2};
			7'd21:                       b = '{bw: 4'd5,  bh: 4'd5, mb: 2'd1};
			7'd22:                       b = '{bw: 4'd6,  bh: 4'd6, mb: 2'd1};
			7'd23:                       b = '{bw: 4'd8,  bh: 4'd5, mb: 2'd1};
			7'd24:                       b = '{bw: 4'd8,  bh: 4'd6, mb: 2'd1};
			7'd25:                       b = '{bw: 4'd10, bh: 4'd5, mb: 2'd1};
			default:                     b = '{bw: 4'd1,  bh: 4'd1, mb: 2'd1};
		endcase
		return b;
	endfunction

	// ceil(2^20 / b); exact quotient for every dividend below 2^17
	function automatic logic [RECIP_W-1:0] recip(input logic [BLK_W-1:0] b);
		logic [RECIP_W-1:0] r;
		case (b)
			4'd4:    r = 21'd262144;
			4'd5:    r = 21'd209716;
			4'd6:    r = 21'd174763;
			4'd8:    r = 21'd131072;
			4'd10:   r = 21'd104858;
			default: r = 21'd1048576;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/mipx_front.sv
// Front pipeline: format decode, block-count division and level-zero alignment.
`timescale 1ns / 1ps
module mipx_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic [mipx_pkg::FMT_W-1:0]         format_index,
	input  logic [mipx_pkg::DIM_W-1:0]         base_width,
	input  logic [mipx_pkg::DIM_W-1:0]         base_height,
	input  logic [mipx_pkg::DIM_W-1:0]         base_depth,
	input  logic [mipx_pkg::CNT_W-1:0]         level_count,
	input  logic [mipx_pkg::LVL_W-1:0]         wanted_level,
	output logic                               out_valid,
	output mipx_pkg::item_t                    out_item
);

	typedef struct packed {
		logic                               comp;
		logic [mipx_pkg::CNT_W-1:0]         steps;
		logic [mipx_pkg::BLK_W-1:0]         bw;
		logic [mipx_pkg::BLK_W-1:0]         bh;
		logic [mipx_pkg::MINB_W-1:0]        mb;
		logic [mipx_pkg::EXT_W-1:0]         xw;
		logic [mipx_pkg::EXT_W-1:0]         xh;
		logic [mipx_pkg::DIM_W-1:0]         d;
	} fr_t;

	logic                               plain;
	logic                               bypass;
	mipx_pkg::blk_t                     blk;
	logic [mipx_pkg::CNT_W-1:0]         lim;
	logic [mipx_pkg::CNT_W-1:0]         lvl1;
	fr_t                                nxt;

	logic                               v_s1, v_s2, v_s3;
	fr_t                                fr_s1, fr_s2;
	logic [mipx_pkg::PROD_W-1:0]        pw_s2, ph_s2;
	mipx_pkg::item_t                    it_s3;

	logic [mipx_pkg::PROD_W-1:0]        pw, ph;
	logic [mipx_pkg::EXT_W-1:0]         qw0, qh0;
	logic [mipx_pkg::EXT_W-1:0]         mbx;

	always_comb begin
		plain  = (format_index >= mipx_pkg::FIRST_PLAIN_FMT);
		bypass = !plain && (level_count == '0);
		lim    = (level_count > mipx_pkg::MAX_LEVELS) ? mipx_pkg::MAX_LEVELS : level_count;
		lvl1   = {1'b0, wanted_level} + 5'd1;
		if (bypass) begin
			blk = '{bw: 4'd1, bh: 4'd1, mb: 2'd0};
		end else begin
			blk = mipx_pkg::blk_of(format_index);
		end
		nxt.comp  = !plain;
		nxt.steps = plain ? lvl1 : ((lvl1 < lim) ? lvl1 : lim);
		nxt.bw    = blk.bw;
		nxt.bh    = blk.bh;
		nxt.mb    = blk.mb;
		nxt.xw    = {1'b0, base_width} + 17'(blk.bw) - 17'd1;
		nxt.xh    = {1'b0, base_height} + 17'(blk.bh) - 17'd1;
		nxt.d     = (!bypass && base_depth == '0) ? 16'd1 : base_depth;
	end

	assign pw  = {21'b0, fr_s1.xw} * {17'b0, mipx_pkg::recip(fr_s1.bw)};
	assign ph  = {21'b0, fr_s1.xh} * {17'b0, mipx_pkg::recip(fr_s1.bh)};
	assign qw0 = pw_s2[mipx_pkg::RECIP_SHIFT +: mipx_pkg::EXT_W];
	assign qh0 = ph_s2[mipx_pkg::RECIP_SHIFT +: mipx_pkg::EXT_W];
	assign mbx = 17'(fr_s2.mb);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		fr_s1       <= nxt;
		fr_s2       <= fr_s1;
		pw_s2       <= pw;
		ph_s2       <= ph;
		it_s3.comp  <= fr_s2.comp;
		it_s3.steps <= fr_s2.steps;
		it_s3.bw    <= fr_s2.bw;
		it_s3.bh    <= fr_s2.bh;
		it_s3.mb    <= fr_s2.mb;
		it_s3.qw    <= (qw0 < mbx) ? mbx : qw0;
		it_s3.qh    <= (qh0 < mbx) ? mbx : qh0;
		it_s3.d     <= fr_s2.d;
	end

	assign out_valid = v_s3;
	assign out_item  = it_s3;

endmodule

// File: rtl/mipx_step.sv
// One mip level step: halve block counts and depth, apply floors.
`timescale 1ns / 1ps
module mipx_step #(
	parameter int unsigned STEP_IDX = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  mipx_pkg::item_t in_item,
	output logic            out_valid,
	output mipx_pkg::item_t out_item
);

	localparam logic [mipx_pkg::CNT_W-1:0] IDX = mipx_pkg::CNT_W'(STEP_IDX);

	logic                               active;
	logic [mipx_pkg::EXT_W:0]           wp1, hp1;
	logic [mipx_pkg::EXT_W-1:0]         hw, hh, mbx;
	logic [mipx_pkg::DIM_W-1:0]         hd;
	mipx_pkg::item_t                    nxt;
	logic                               v_q;
	mipx_pkg::item_t                    it_q;

	always_comb begin
		active = (in_item.steps > IDX);
		mbx    = 17'(in_item.mb);
		wp1    = {1'b0, in_item.qw} + 18'd1;
		hp1    = {1'b0, in_item.qh} + 18'd1;
		hw     = in_item.comp ? wp1[mipx_pkg::EXT_W:1] : (in_item.qw >> 1);
		hh     = in_item.comp ? hp1[mipx_pkg::EXT_W:1] : (in_item.qh >> 1);
		hd     = in_item.d >> 1;
		nxt    = in_item;
		if (active) begin
			nxt.qw = (hw < mbx) ? mbx : hw;
			nxt.qh = (hh < mbx) ? mbx : hh;
			nxt.d  = (hd == '0) ? 16'd1 : hd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		it_q <= nxt;
	end

	assign out_valid = v_q;
	assign out_item  = it_q;

endmodule

// File: rtl/mipx_scale.sv
// Output stage: block counts back to texels, result registers and strobe.
`timescale 1ns / 1ps
module mipx_scale (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  mipx_pkg::item_t              in_item,
	output logic                         done,
	output logic [mipx_pkg::EXT_W-1:0]   mip_width,
	output logic [mipx_pkg::EXT_W-1:0]   mip_height,
	output logic [mipx_pkg::DIM_W-1:0]   mip_depth
);

	logic [mipx_pkg::EXT_W+mipx_pkg::BLK_W-1:0] pw, ph;
	logic                                       done_q;
	logic [mipx_pkg::EXT_W-1:0]                 w_q, h_q;
	logic [mipx_pkg::DIM_W-1:0]                 d_q;

	assign pw = {4'b0, in_item.qw} * {17'b0, in_item.bw};
	assign ph = {4'b0, in_item.qh} * {17'b0, in_item.bh};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		w_q <= pw[mipx_pkg::EXT_W-1:0];
		h_q <= ph[mipx_pkg::EXT_W-1:0];
		d_q <= in_item.d;
	end

	assign done       = done_q;
	assign mip_width  = w_q;
	assign mip_height = h_q;
	assign mip_depth  = d_q;

endmodule

// File: rtl/texture_mip_extent_unit.sv
// Top level of the mip level extent pipeline.
//
// channel   direction  handshake            payload
// command   in         start, busy          format_index, base_width, base_height,
//                                           base_depth, level_count, wanted_level
// result    out        done (one cycle)     mip_width, mip_height, mip_depth
//
// One transaction per cycle; busy stays low, every start is taken.
// The pipeline has three front stages (decode, reciprocal multiply,
// alignment), fifteen level stages and one output stage.
// arst_n clears all valid bits; no transaction survives reset.
// The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps
module texture_mip_extent_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [mipx_pkg::FMT_W-1:0]         format_index,
	input  logic [mipx_pkg::DIM_W-1:0]         base_width,
	input  logic [mipx_pkg::DIM_W-1:0]         base_height,
	input  logic [mipx_pkg::DIM_W-1:0]         base_depth,
	input  logic [mipx_pkg::CNT_W-1:0]         level_count,
	input  logic [mipx_pkg::LVL_W-1:0]         wanted_level,
	output logic                               done,
	output logic [mipx_pkg::EXT_W-1:0]         mip_width,
	output logic [mipx_pkg::EXT_W-1:0]         mip_height,
	output logic [mipx_pkg::DIM_W-1:0]         mip_depth
);

	logic                   vld [mipx_pkg::WALK_STEPS+1];
	mipx_pkg::item_t        itm [mipx_pkg::WALK_STEPS+1];

	assign busy = 1'b0;

	mipx_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (start),
		.format_index (format_index),
		.base_width   (base_width),
		.base_height  (base_height),
		.base_depth   (base_depth),
		.level_count  (level_count),
		.wanted_level (wanted_level),
		.out_valid    (vld[0]),
		.out_item     (itm[0])
	);

	for (genvar g = 0; g < mipx_pkg::WALK_STEPS; g++) begin : g_walk
		mipx_step #(
			.STEP_IDX (g + 1)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld[g]),
			.in_item   (itm[g]),
			.out_valid (vld[g+1]),
			.out_item  (itm[g+1])
		);
	end

	mipx_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (vld[mipx_pkg::WALK_STEPS]),
		.in_item    (itm[mipx_pkg::WALK_STEPS]),
		.done       (done),
		.mip_width  (mip_width),
		.mip_height (mip_height),
		.mip_depth  (mip_depth)
	);

endmodule

// File: rtl/mipx_checker.sv
// Port-level checks for the mip extent unit, bound to the top level.
`timescale 1ns / 1ps
module mipx_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  logic [mipx_pkg::FMT_W-1:0]         format_index,
	input  logic [mipx_pkg::DIM_W-1:0]         base_width,
	input  logic [mipx_pkg::CNT_W-1:0]         level_count,
	input  logic                               done,
	input  logic [mipx_pkg::EXT_W-1:0]         mip_width,
	input  logic [mipx_pkg::EXT_W-1:0]         mip_height,
	input  logic [mipx_pkg::DIM_W-1:0]         mip_depth
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(mipx_pkg::LATENCY) done)
		else $error("transaction lost");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, mipx_pkg::LATENCY))
		else $error("result without transaction");

	a_plain_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(format_index >= mipx_pkg::FIRST_PLAIN_FMT, mipx_pkg::LATENCY)
		|-> mip_width != '0 && mip_height != '0 && mip_depth != '0)
		else $error("zero extent on uncompressed format");

	a_zero_levels: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(format_index < mipx_pkg::FIRST_PLAIN_FMT && level_count == '0,
			mipx_pkg::LATENCY)
		|-> mip_width == {1'b0, $past(base_width, mipx_pkg::LATENCY)})
		else $error("zero level count changed width");

endmodule

bind texture_mip_extent_unit mipx_checker u_mipx_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.format_index (format_index),
	.base_width   (base_width),
	.level_count  (level_count),
	.done         (done),
	.mip_width    (mip_width),
	.mip_height   (mip_height),
	.mip_depth    (mip_depth)
);

// File: tb/sv/mip_extent_checker.sv
// Checker that predicts each mip level extent and compares it with the result port.
`timescale 1ns / 1ps
module mip_extent_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  logic [mipx_pkg::FMT_W-1:0]         format_index,
	input  logic [mipx_pkg::DIM_W-1:0]         base_width,
	input  logic [mipx_pkg::DIM_W-1:0]         base_height,
	input  logic [mipx_pkg::DIM_W-1:0]         base_depth,
	input  logic [mipx_pkg::CNT_W-1:0]         level_count,
	input  logic [mipx_pkg::LVL_W-1:0]         wanted_level,
	input  logic                               done,
	input  logic [mipx_pkg::EXT_W-1:0]         mip_width,
	input  logic [mipx_pkg::EXT_W-1:0]         mip_height,
	input  logic [mipx_pkg::DIM_W-1:0]         mip_depth,
	output int                                 mismatches,
	output int                                 outstanding
);
	import mipx_pkg::*;

	typedef struct packed {
		logic [EXT_W-1:0] w;
		logic [EXT_W-1:0] h;
		logic [DIM_W-1:0] d;
	} extent_t;

	extent_t pending_extents[$];

	function automatic void block_shape(input logic [FMT_W-1:0] fmt,
			output int unsigned bw, output int unsigned bh, output int unsigned mb);
		bw = 4;
		bh = 4;
		mb = 1;
		case (fmt)
			7'd11, 7'd13, 7'd15: begin
				bw = 8;
				mb = 2;
			end
			7'd12, 7'd14, 7'd16: mb = 2;
			7'd21: begin
				bw = 5;
				bh = 5;
			end
			7'd22: begin
				bw = 6;
				bh = 6;
			end
			7'd23: begin
				bw = 8;
				bh = 5;
			end
			7'd24: begin
				bw = 8;
				bh = 6;
			end
			7'd25: begin
				bw = 10;
				bh = 5;
			end
			default: ;
		endcase
	endfunction

	function automatic int unsigned round_to_block(input int unsigned v, input int unsigned b,
			input int unsigned mb);
		int unsigned r;
		r = ((v + b - 1) / b) * b;
		return (r < b * mb) ? b * mb : r;
	endfunction

	function automatic extent_t level_extent(input logic [FMT_W-1:0] fmt,
			input logic [DIM_W-1:0] bw_in, input logic [DIM_W-1:0] bh_in,
			input logic [DIM_W-1:0] bd_in, input logic [CNT_W-1:0] levels,
			input logic [LVL_W-1:0] lvl);
		int unsigned w, h, d, bw, bh, mb, steps;
		extent_t e;
		w = 32'(bw_in);
		h = 32'(bh_in);
		d = 32'(bd_in);
		if (fmt >= FIRST_PLAIN_FMT) begin
			w = w >> lvl;
			h = h >> lvl;
			d = d >> lvl;
			if (w == 0) w = 1;
			if (h == 0) h = 1;
			if (d == 0) d = 1;
		end else begin
			block_shape(fmt, bw, bh, mb);
			steps = 32'((levels > MAX_LEVELS) ? MAX_LEVELS : levels);
			for (int unsigned i = 0; i <= 32'(lvl) && i < steps; i++) begin
				if (i > 0) begin
					w = w >> 1;
					h = h >> 1;
					d = d >> 1;
				end
				w = round_to_block(w, bw, mb);
				h = round_to_block(h, bh, mb);
				if (d == 0) d = 1;
			end
		end
		e.w = w[EXT_W-1:0];
		e.h = h[EXT_W-1:0];
		e.d = d[DIM_W-1:0];
		return e;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	initial mismatches = 0;

	assign outstanding = pending_extents.size();

	always @(posedge clk) begin
		extent_t want;
		if (arst_n) begin
			if (start && !busy)
				pending_extents.push_back(level_extent(format_index, base_width, base_height,
					base_depth, level_count, wanted_level));
			if (done) begin
				if (pending_extents.size() == 0) begin
					$display("%0t: expected no result, got %0d %0d %0d",
						$time, mip_width, mip_height, mip_depth);
					mismatches++;
				end else begin
					want = pending_extents.pop_front();
					check_field("mip_width", 32'(want.w), 32'(mip_width));
					check_field("mip_height", 32'(want.h), 32'(mip_height));
					check_field("mip_depth", 32'(want.d), 32'(mip_depth));
				end
			end
		end
	end
endmodule

// File: tb/sv/tb.sv
// Testbench top: drives mip extent queries into the unit and reports the verdict.
`timescale 1ns / 1ps
module tb;
	import mipx_pkg::*;

	localparam int RANDOM_ITEMS = 1800;
	localparam int CYCLE_LIMIT  = 200000;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [FMT_W-1:0]     format_index;
	logic [DIM_W-1:0]     base_width;
	logic [DIM_W-1:0]     base_height;
	logic [DIM_W-1:0]     base_depth;
	logic [CNT_W-1:0]     level_count;
	logic [LVL_W-1:0]     wanted_level;
	logic                 done;
	logic [EXT_W-1:0]     mip_width;
	logic [EXT_W-1:0]     mip_height;
	logic [DIM_W-1:0]     mip_depth;
	int                   mismatches;
	int                   outstanding;
	int                   cycles;
	bit                   no_idle;

	texture_mip_extent_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.format_index (format_index),
		.base_width   (base_width),
		.base_height  (base_height),
		.base_depth   (base_depth),
		.level_count  (level_count),
		.wanted_level (wanted_level),
		.done         (done),
		.mip_width    (mip_width),
		.mip_height   (mip_height),
		.mip_depth    (mip_depth)
	);

	mip_extent_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.format_index (format_index),
		.base_width   (base_width),
		.base_height  (base_height),
		.base_depth   (base_depth),
		.level_count  (level_count),
		.wanted_level (wanted_level),
		.done         (done),
		.mip_width    (mip_width),
		.mip_height   (mip_height),
		.mip_depth    (mip_depth),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial cycles = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic issue_query(input logic [FMT_W-1:0] fmt, input logic [DIM_W-1:0] w,
			input logic [DIM_W-1:0] h, input logic [DIM_W-1:0] d,
			input logic [CNT_W-1:0] levels, input logic [LVL_W-1:0] lvl);
		int gap;
		bit was_busy;
		gap = no_idle ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		format_index <= fmt;
		base_width   <= w;
		base_height  <= h;
		base_depth   <= d;
		level_count  <= levels;
		wanted_level <= lvl;
		forever begin
			@(negedge clk);
			was_busy = busy;
			@(posedge clk);
			if (!was_busy) break;
		end
	endtask

	function automatic logic [DIM_W-1:0] pick_dim();
		case ($urandom_range(0, 3))
			0:       return DIM_W'($urandom_range(0, 16'hFFFF));
			1:       return DIM_W'($urandom_range(0, 64));
			2:       return 16'd1 << $urandom_range(0, DIM_W - 1);
			default: return $urandom_range(0, 1) ? 16'hFFFF - DIM_W'($urandom_range(0, 3))
				: DIM_W'($urandom_range(0, 2));
		endcase
	endfunction

	task automatic drain();
		forever begin
			@(negedge clk);
			if (outstanding == 0) break;
		end
	endtask

	initial begin
		logic [FMT_W-1:0] fmt;
		logic [CNT_W-1:0] levels;
		arst_n       <= 1'b0;
		start        <= 1'b0;
		format_index <= '0;
		base_width   <= '0;
		base_height  <= '0;
		base_depth   <= '0;
		level_count  <= '0;
		wanted_level <= '0;
		no_idle      = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every block shape, zero and full dimensions, both level extremes
		issue_query(7'd0,   16'd0,     16'd0,     16'd0,     5'd16, 4'd15);
		issue_query(7'd10,  16'hFFFF,  16'hFFFF,  16'hFFFF,  5'd16, 4'd0);
		issue_query(7'd11,  16'hFFFF,  16'hFFFF,  16'hFFFF,  5'd16, 4'd15);
		issue_query(7'd12,  16'd1,     16'd1,     16'd1,     5'd16, 4'd15);
		issue_query(7'd17,  16'd100,   16'd37,    16'd9,     5'd5,  4'd3);
		issue_query(7'd21,  16'hFFFF,  16'd1000,  16'd0,     5'd16, 4'd4);
		issue_query(7'd22,  16'd1023,  16'hFFFF,  16'd7,     5'd16, 4'd15);
		issue_query(7'd23,  16'd333,   16'd777,   16'd64,    5'd16, 4'd9);
		issue_query(7'd24,  16'hFFFE,  16'hFFFD,  16'd3,     5'd16, 4'd2);
		issue_query(7'd25,  16'hFFFF,  16'hFFFF,  16'hFFFF,  5'd16, 4'd1);
		// zero level count leaves the base untouched
		issue_query(7'd25,  16'd3,     16'd3,     16'd0,     5'd0,  4'd15);
		issue_query(7'd13,  16'hFFFF,  16'd0,     16'd0,     5'd0,  4'd0);
		// level count beyond the cap, then a level count of one
		issue_query(7'd14,  16'd5000,  16'd5000,  16'd5000,  5'd31, 4'd15);
		issue_query(7'd16,  16'd17,    16'd9,     16'd2,     5'd17, 4'd8);
		issue_query(7'd15,  16'd9,     16'd200,   16'd0,     5'd1,  4'd15);
		// plain formats, unused codes included
		issue_query(7'd26,  16'hFFFF,  16'hFFFF,  16'hFFFF,  5'd0,  4'd0);
		issue_query(7'd26,  16'hFFFF,  16'hFFFF,  16'hFFFF,  5'd0,  4'd15);
		issue_query(7'd84,  16'd0,     16'd0,     16'd0,     5'd31, 4'd0);
		issue_query(7'd85,  16'd1234,  16'd4321,  16'd77,    5'd3,  4'd5);
		issue_query(7'd127, 16'h8000,  16'h4000,  16'h0001,  5'd16, 4'd14);
		issue_query(7'd127, 16'h5555,  16'hAAAA,  16'h5555,  5'd10, 4'd1);

		// hold off until the pipeline has emptied
		start <= 1'b0;
		drain();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 64 == 0)
				no_idle = ($urandom_range(0, 4) == 0);
			fmt = FMT_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 25)
				: $urandom_range(26, 127));
			levels = CNT_W'(($urandom_range(0, 6) == 0) ? $urandom_range(17, 31)
				: $urandom_range(0, 16));
			issue_query(fmt, pick_dim(), pick_dim(), pick_dim(), levels,
				LVL_W'($urandom_range(0, 15)));
		end

		start <= 1'b0;
		drain();
		repeat (LATENCY + 4) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

// File: files.f
rtl/mipx_pkg.sv
rtl/mipx_front.sv
rtl/mipx_step.sv
rtl/mipx_scale.sv
rtl/texture_mip_extent_unit.sv
rtl/mipx_checker.sv
tb/sv/mip_extent_checker.sv
tb/sv/tb.sv
